>>> design/assert_macros.svh
// Assertion macros used by the sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/sbs_pkg.sv
// Types, codes and constants of the sort beat sequencer.
package sbs_pkg;

  localparam int BTN_W  = 4;
  localparam int AXIS_W = 3;
  localparam int DEST_W = 3;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_WAIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMING_PRESS = 2'd2;

  localparam logic [15:0] SCAN_PERIOD_RST  = 16'd50;
  localparam logic [15:0] SLIDE_WAIT_RST   = 16'd2000;
  localparam logic [2:0]  HOMING_PRESS_RST = 3'd2;

  // Route codes
  localparam logic [1:0] ROUTE_NEUTRAL = 2'd0;
  localparam logic [1:0] ROUTE_LEFT    = 2'd1;
  localparam logic [1:0] ROUTE_RIGHT   = 2'd2;

  // Stage positions
  localparam logic [1:0] STAGE_FIRST  = 2'd0;
  localparam logic [1:0] STAGE_SECOND = 2'd1;
  localparam logic [1:0] STAGE_THIRD  = 2'd2;

  typedef struct packed {
    logic [31:0]       now_ms;
    logic [BTN_W-1:0]  buttons;
    logic [AXIS_W-1:0] endstops;
    logic              motors_busy;
  } pass_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic              load_targets;
    logic [1:0]        route_x;
    logic [1:0]        route_y;
    logic [1:0]        route_z;
    logic [AXIS_W-1:0] homing_drive;
    logic [AXIS_W-1:0] rezero;
    logic [3:0]        queued_items;
  } result_t;

  // Queue control from the sequencer for one pass
  typedef struct packed {
    logic             step;
    logic             flush;
    logic             pop;
    logic [BTN_W-1:0] edges;
  } qctl_t;

  // Queue status for the same pass
  typedef struct packed {
    logic              nonempty;
    logic [3:0]        count_low;
    logic [DEST_W-1:0] pop_dest;
  } qstat_t;

  function automatic logic [1:0] route_of(input logic [1:0] stage,
                                          input logic [DEST_W-1:0] dest);
    logic [1:0] r;
    r = ROUTE_NEUTRAL;
    if (dest != '0) begin
      case (stage)
        STAGE_FIRST: begin
          r = (dest == 3'd1) ? ROUTE_LEFT : ROUTE_RIGHT;
        end
        STAGE_SECOND: begin
          if (dest == 3'd1) r = ROUTE_NEUTRAL;
          else if (dest == 3'd2) r = ROUTE_RIGHT;
          else r = ROUTE_LEFT;
        end
        default: begin
          if (dest == 3'd1 || dest == 3'd2) r = ROUTE_NEUTRAL;
          else if (dest == 3'd3) r = ROUTE_LEFT;
          else r = ROUTE_RIGHT;
        end
      endcase
    end
    return r;
  endfunction

endpackage

>>> design/sbs_if.sv
// Valid/ready channels for controller passes and results.
interface sbs_pass_if;
  logic          valid;
  logic          ready;
  sbs_pkg::pass_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sbs_result_if;
  logic            valid;
  logic            ready;
  sbs_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/sbs_dest_queue.sv
// Destination queue: one record of accepted press edges per scan, popped one destination at a time.
module sbs_dest_queue #(
  parameter int QUEUE_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  sbs_pkg::qctl_t  ctl,
  output sbs_pkg::qstat_t stat
);

  localparam int PW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

  // Each record is a nonzero mask of destinations pushed in one scan, in
  // button order. Record count never exceeds entry count, so it cannot overflow.
  logic [sbs_pkg::BTN_W-1:0] rec_mem [QUEUE_SLOTS];
  logic [sbs_pkg::BTN_W-1:0] rd_data;
  logic [sbs_pkg::BTN_W-1:0] taken, taken_next;
  logic [PW-1:0] rec_wr, rec_wr_next;
  logic [PW-1:0] rec_rd, rec_rd_next;
  logic [PW-1:0] cnt, cnt_next, cnt_push, cnt_final, space;

  logic [sbs_pkg::BTN_W-1:0] acc, front, low, front_left;
  logic [2:0] nacc;
  logic [sbs_pkg::DEST_W-1:0] dest;
  logic found, popping, rec_empty, rec_we;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    space = PW'(QUEUE_SLOTS - 1) - cnt;
    acc   = '0;
    nacc  = '0;
    // pushes into a full ring drop, so only the first edges that fit are kept
    for (int i = 0; i < sbs_pkg::BTN_W; i++) begin
      if (ctl.edges[i] && (PW'(nacc) < space)) begin
        acc[i] = 1'b1;
        nacc   = nacc + 3'd1;
      end
    end
    cnt_push = cnt + PW'(nacc);

    rec_empty = (rec_rd == rec_wr);
    // an empty ring pops straight from the record being written
    front = rec_empty ? acc : (rd_data & ~taken);
    low   = '0;
    found = 1'b0;
    dest  = '0;
    for (int i = 0; i < sbs_pkg::BTN_W; i++) begin
      if (front[i] && !found) begin
        low[i] = 1'b1;
        found  = 1'b1;
        dest   = sbs_pkg::DEST_W'(i + 1);
      end
    end
    popping    = ctl.pop && found;
    front_left = front & ~low;

    rec_we    = ctl.step && !ctl.flush && (acc != '0);
    cnt_final = ctl.flush ? '0 : cnt_push - PW'(popping);

    rec_wr_next = rec_wr;
    rec_rd_next = rec_rd;
    taken_next  = taken;
    cnt_next    = cnt;
    if (ctl.step) begin
      cnt_next = cnt_final;
      if (ctl.flush) begin
        rec_wr_next = '0;
        rec_rd_next = '0;
        taken_next  = '0;
      end else begin
        if (rec_we) rec_wr_next = ptr_inc(rec_wr);
        if (popping) begin
          if (front_left == '0) begin
            rec_rd_next = ptr_inc(rec_rd);
            taken_next  = '0;
          end else begin
            taken_next = taken | low;
          end
        end
      end
    end

    stat.nonempty  = (cnt_push != '0);
    stat.count_low = 4'(cnt_final);
    stat.pop_dest  = popping ? dest : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_wr <= '0;
      rec_rd <= '0;
      taken  <= '0;
      cnt    <= '0;
    end else begin
      rec_wr <= rec_wr_next;
      rec_rd <= rec_rd_next;
      taken  <= taken_next;
      cnt    <= cnt_next;
    end
  end

  // rd_data always shows the record at the read pointer, forwarding a same-cycle write
  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wr] <= acc;
    rd_data <= (rec_we && (rec_wr == rec_rd_next)) ? acc : rec_mem[rec_rd_next];
  end

endmodule

>>> design/three_stage_sort_beat_sequencer.sv
// Sort beat sequencer top level: button scan, beat state machine, homing and result register.
// One controller pass is taken per clock; its result appears in the output
// register on the next cycle, and a new pass is taken while that result waits
// as long as the result side takes it in the same cycle. The figure is set by
// the single next-state path: the two 32-bit elapsed-time compares and the
// queue push/pop logic. The destination queue stores one record of accepted
// press edges per scan in a QUEUE_SLOTS-deep memory with a registered read;
// it is tracked by pointers and a fill count, so no clearing pass follows reset.
`include "assert_macros.svh"

module three_stage_sort_beat_sequencer #(
  parameter int QUEUE_SLOTS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbs_pkg::CFG_W-1:0]       cfg_data,
  sbs_pass_if.sink                        pass,
  sbs_result_if.source                    result
);

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_PREP   = 3'd1,
    MODE_MOVING = 3'd2,
    MODE_SLIDE  = 3'd3,
    MODE_DONE   = 3'd4,
    MODE_HOMING = 3'd5
  } mode_t;

  logic [15:0] scan_period;
  logic [15:0] slide_wait;
  logic [2:0]  homing_press;

  mode_t mode, mode_scan, mode_next;
  logic [31:0] last_scan, last_scan_next;
  logic [sbs_pkg::BTN_W-1:0] levels, levels_next;
  logic [sbs_pkg::DEST_W-1:0] stages [3];
  logic [sbs_pkg::DEST_W-1:0] stages_scan [3];
  logic [sbs_pkg::DEST_W-1:0] stages_next [3];
  logic [31:0] slide_start, slide_start_next;
  logic homing_started, homing_started_next;
  logic [sbs_pkg::AXIS_W-1:0] axes_homed, axes_homed_next, homed_base;

  logic accept, scan_go, flush;
  logic [2:0] held;
  sbs_pkg::qctl_t  qctl;
  sbs_pkg::qstat_t qstat;
  sbs_pkg::result_t res_next;

  assign accept     = pass.valid && pass.ready;
  assign pass.ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period  <= sbs_pkg::SCAN_PERIOD_RST;
      slide_wait   <= sbs_pkg::SLIDE_WAIT_RST;
      homing_press <= sbs_pkg::HOMING_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sbs_pkg::CFG_SCAN_PERIOD:  scan_period  <= cfg_data;
        sbs_pkg::CFG_SLIDE_WAIT:   slide_wait   <= cfg_data;
        sbs_pkg::CFG_HOMING_PRESS: homing_press <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Button scan, then one step of the mode machine on the mode it leaves
  always_comb begin
    scan_go = (pass.data.now_ms - last_scan) >= 32'(scan_period);
    held    = 3'($countones(pass.data.buttons));
    flush   = scan_go && (held >= homing_press) && (mode != MODE_HOMING);

    last_scan_next = scan_go ? pass.data.now_ms : last_scan;
    levels_next    = scan_go ? pass.data.buttons : levels;

    qctl.step  = accept;
    qctl.flush = flush;
    qctl.edges = scan_go ? (pass.data.buttons & ~levels) : '0;

    mode_scan = flush ? MODE_HOMING : mode;
    for (int i = 0; i < 3; i++) stages_scan[i] = flush ? '0 : stages[i];
    qctl.pop = (mode_scan == MODE_PREP);

    mode_next           = mode_scan;
    stages_next         = stages_scan;
    slide_start_next    = slide_start;
    homing_started_next = homing_started;
    axes_homed_next     = axes_homed;
    homed_base          = homing_started ? axes_homed : '0;
    res_next            = '0;

    case (mode_scan)
      MODE_IDLE: begin
        if (qstat.nonempty || stages_scan[0] != '0 || stages_scan[1] != '0 ||
            stages_scan[2] != '0) begin
          mode_next = MODE_PREP;
        end
      end
      MODE_PREP: begin
        stages_next[2] = stages_scan[1];
        stages_next[1] = stages_scan[0];
        stages_next[0] = qstat.pop_dest;
        res_next.load_targets = 1'b1;
        res_next.route_x = sbs_pkg::route_of(sbs_pkg::STAGE_FIRST, qstat.pop_dest);
        res_next.route_y = sbs_pkg::route_of(sbs_pkg::STAGE_SECOND, stages_scan[0]);
        res_next.route_z = sbs_pkg::route_of(sbs_pkg::STAGE_THIRD, stages_scan[1]);
        mode_next = MODE_MOVING;
      end
      MODE_MOVING: begin
        if (!pass.data.motors_busy) begin
          slide_start_next = pass.data.now_ms;
          mode_next        = MODE_SLIDE;
        end
      end
      MODE_SLIDE: begin
        if ((pass.data.now_ms - slide_start) >= 32'(slide_wait)) mode_next = MODE_DONE;
      end
      MODE_DONE: begin
        mode_next = MODE_IDLE;
      end
      MODE_HOMING: begin
        res_next.homing_drive = ~homed_base & ~pass.data.endstops;
        res_next.rezero       = ~homed_base & pass.data.endstops;
        axes_homed_next       = homed_base | pass.data.endstops;
        homing_started_next   = 1'b1;
        if (axes_homed_next == '1) begin
          homing_started_next   = 1'b0;
          res_next.load_targets = 1'b1;
          mode_next             = MODE_IDLE;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    res_next.mode         = mode_next;
    res_next.queued_items = qstat.count_low;
  end

  sbs_dest_queue #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (qctl),
    .stat (qstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      last_scan      <= '0;
      levels         <= '0;
      stages[0]      <= '0;
      stages[1]      <= '0;
      stages[2]      <= '0;
      slide_start    <= '0;
      homing_started <= 1'b0;
      axes_homed     <= '0;
      result.valid   <= 1'b0;
    end else begin
      if (accept) begin
        mode           <= mode_next;
        last_scan      <= last_scan_next;
        levels         <= levels_next;
        stages         <= stages_next;
        slide_start    <= slide_start_next;
        homing_started <= homing_started_next;
        axes_homed     <= axes_homed_next;
        result.valid   <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) result.data <= res_next;
  end

  `ASSERT_CLK(a_load_mode, clk, rst, (result.valid && result.data.load_targets) |-> (result.data.mode == MODE_MOVING || result.data.mode == MODE_IDLE), "targets issued outside prepare or homing exit")
  `ASSERT_CLK(a_route_idle, clk, rst, (result.valid && !result.data.load_targets) |-> (result.data.route_x == '0 && result.data.route_y == '0 && result.data.route_z == '0), "route set without a target load")
  `ASSERT_CLK(a_homing_bits, clk, rst, (result.valid && (result.data.homing_drive != '0 || result.data.rezero != '0)) |-> ((result.data.homing_drive & result.data.rezero) == '0 && (result.data.mode == MODE_HOMING || result.data.mode == MODE_IDLE)), "homing outputs inconsistent with mode")
  `ASSERT_CLK(a_flush_empty, clk, rst, (accept && flush) |=> (result.data.queued_items == '0 && (result.data.mode == MODE_HOMING || result.data.mode == MODE_IDLE)), "flush left queue entries or wrong mode")

endmodule

>>> tb/tb_three_stage_sort_beat_sequencer.sv
// Self-checking testbench for the sort beat sequencer: shaped random passes against a predictor.
`timescale 1ns / 100ps

module tb_three_stage_sort_beat_sequencer;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_PREP   = 3'd1,
    MODE_MOVING = 3'd2,
    MODE_SLIDE  = 3'd3,
    MODE_DONE   = 3'd4,
    MODE_HOMING = 3'd5
  } mode_t;

  localparam int RING_SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [sbs_pkg::CFG_IDX_W-1:0] cfg_index = sbs_pkg::CFG_SCAN_PERIOD;
  logic [sbs_pkg::CFG_W-1:0] cfg_data = '0;
  logic drv_valid = 1'b0;
  sbs_pkg::pass_t drv_data = '0;
  logic rdy = 1'b0;

  sbs_pass_if pass_ch ();
  sbs_result_if res_ch ();

  assign pass_ch.valid = drv_valid;
  assign pass_ch.data  = drv_data;
  assign res_ch.ready  = rdy;

  three_stage_sort_beat_sequencer #(.QUEUE_SLOTS(RING_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pass      (pass_ch),
    .result    (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state
  logic [15:0] m_scan_period = sbs_pkg::SCAN_PERIOD_RST;
  logic [15:0] m_slide_wait = sbs_pkg::SLIDE_WAIT_RST;
  logic [2:0] m_press_count = sbs_pkg::HOMING_PRESS_RST;
  mode_t m_mode = MODE_IDLE;
  logic [31:0] m_last_scan = '0;
  logic [3:0] m_levels = '0;
  logic [2:0] m_ring [RING_SLOTS];
  logic [3:0] m_wr = '0;
  logic [3:0] m_rd = '0;
  logic [2:0] m_stage [3] = '{3'd0, 3'd0, 3'd0};
  logic [31:0] m_slide_start = '0;
  logic m_homing_started = 1'b0;
  logic [2:0] m_homed = '0;

  sbs_pkg::pass_t pass_backlog[$];
  sbs_pkg::result_t awaited_results[$];
  sbs_pkg::result_t want;
  logic pass_xfer = 1'b0;
  int results_seen = 0;
  int errors = 0;
  int cycle_count = 0;
  bit idle_on = 1'b0;
  int gap_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  logic [31:0] t_now = '0;
  logic [3:0] held_btn = '0;

  function automatic void ring_push(logic [2:0] dest);
    if (m_wr + 4'd1 != m_rd) begin
      m_ring[m_wr] = dest;
      m_wr = m_wr + 4'd1;
    end
  endfunction

  function automatic logic [2:0] ring_pop();
    logic [2:0] v;
    v = '0;
    if (m_wr != m_rd) begin
      v = m_ring[m_rd];
      m_rd = m_rd + 4'd1;
    end
    return v;
  endfunction

  function automatic logic [1:0] route_code(logic [1:0] stage, logic [2:0] dest);
    logic [1:0] r;
    r = sbs_pkg::ROUTE_NEUTRAL;
    if (dest != 3'd0) begin
      if (stage == sbs_pkg::STAGE_FIRST) begin
        r = (dest == 3'd1) ? sbs_pkg::ROUTE_LEFT : sbs_pkg::ROUTE_RIGHT;
      end else if (stage == sbs_pkg::STAGE_SECOND) begin
        if (dest == 3'd2) r = sbs_pkg::ROUTE_RIGHT;
        else if (dest != 3'd1) r = sbs_pkg::ROUTE_LEFT;
      end else begin
        if (dest == 3'd3) r = sbs_pkg::ROUTE_LEFT;
        else if (dest != 3'd1 && dest != 3'd2) r = sbs_pkg::ROUTE_RIGHT;
      end
    end
    return r;
  endfunction

  // One controller pass: scan first, then one step of the beat machine
  function automatic sbs_pkg::result_t predict_beat(sbs_pkg::pass_t p);
    sbs_pkg::result_t r;
    int held;
    int i;
    r = '0;
    held = 0;
    if (p.now_ms - m_last_scan >= {16'd0, m_scan_period}) begin
      m_last_scan = p.now_ms;
      for (i = 0; i < 4; i++) begin
        if (p.buttons[i] != m_levels[i]) begin
          if (p.buttons[i]) ring_push(3'(i + 1));
          m_levels[i] = p.buttons[i];
        end
      end
      for (i = 0; i < 4; i++) held += int'(m_levels[i]);
      if (held >= int'(m_press_count) && m_mode != MODE_HOMING) begin
        m_wr = '0;
        m_rd = '0;
        m_stage = '{3'd0, 3'd0, 3'd0};
        m_mode = MODE_HOMING;
      end
    end
    case (m_mode)
      MODE_IDLE: begin
        if (m_wr != m_rd || m_stage[0] != 0 || m_stage[1] != 0 || m_stage[2] != 0)
          m_mode = MODE_PREP;
      end
      MODE_PREP: begin
        m_stage[2] = m_stage[1];
        m_stage[1] = m_stage[0];
        m_stage[0] = ring_pop();
        r.load_targets = 1'b1;
        r.route_x = route_code(sbs_pkg::STAGE_FIRST, m_stage[0]);
        r.route_y = route_code(sbs_pkg::STAGE_SECOND, m_stage[1]);
        r.route_z = route_code(sbs_pkg::STAGE_THIRD, m_stage[2]);
        m_mode = MODE_MOVING;
      end
      MODE_MOVING: begin
        if (!p.motors_busy) begin
          m_slide_start = p.now_ms;
          m_mode = MODE_SLIDE;
        end
      end
      MODE_SLIDE: begin
        if (p.now_ms - m_slide_start >= {16'd0, m_slide_wait}) m_mode = MODE_DONE;
      end
      MODE_DONE: m_mode = MODE_IDLE;
      MODE_HOMING: begin
        if (!m_homing_started) begin
          m_homed = '0;
          m_homing_started = 1'b1;
        end
        for (i = 0; i < 3; i++) begin
          if (!m_homed[i]) begin
            if (p.endstops[i]) begin
              r.rezero[i] = 1'b1;
              m_homed[i] = 1'b1;
            end else begin
              r.homing_drive[i] = 1'b1;
            end
          end
        end
        if (m_homed == 3'b111) begin
          m_homing_started = 1'b0;
          r.load_targets = 1'b1;
          m_mode = MODE_IDLE;
        end
      end
      default: m_mode = MODE_IDLE;
    endcase
    r.mode = m_mode;
    r.queued_items = m_wr - m_rd;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    errors++;
    $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, exp_val);
  endtask

  // Monitor: predicts on each input transfer, checks each output transfer
  always @(posedge clk) begin
    if (rst) begin
      pass_xfer <= 1'b0;
    end else begin
      pass_xfer <= pass_ch.valid && pass_ch.ready;
      if (cfg_we) begin
        case (cfg_index)
          sbs_pkg::CFG_SCAN_PERIOD:  m_scan_period = cfg_data;
          sbs_pkg::CFG_SLIDE_WAIT:   m_slide_wait = cfg_data;
          sbs_pkg::CFG_HOMING_PRESS: m_press_count = cfg_data[2:0];
          default: ;
        endcase
      end
      if (pass_ch.valid && pass_ch.ready)
        awaited_results.push_back(predict_beat(pass_ch.data));
      if (res_ch.valid && res_ch.ready) begin
        results_seen <= results_seen + 1;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(res_ch.data), '0);
        end else begin
          want = awaited_results.pop_front();
          if (res_ch.data.mode != want.mode)
            report_mismatch("mode", 32'(res_ch.data.mode), 32'(want.mode));
          if (res_ch.data.load_targets != want.load_targets)
            report_mismatch("load_targets", 32'(res_ch.data.load_targets),
                            32'(want.load_targets));
          if (res_ch.data.route_x != want.route_x)
            report_mismatch("route_x", 32'(res_ch.data.route_x), 32'(want.route_x));
          if (res_ch.data.route_y != want.route_y)
            report_mismatch("route_y", 32'(res_ch.data.route_y), 32'(want.route_y));
          if (res_ch.data.route_z != want.route_z)
            report_mismatch("route_z", 32'(res_ch.data.route_z), 32'(want.route_z));
          if (res_ch.data.homing_drive != want.homing_drive)
            report_mismatch("homing_drive", 32'(res_ch.data.homing_drive),
                            32'(want.homing_drive));
          if (res_ch.data.rezero != want.rezero)
            report_mismatch("rezero", 32'(res_ch.data.rezero), 32'(want.rezero));
          if (res_ch.data.queued_items != want.queued_items)
            report_mismatch("queued_items", 32'(res_ch.data.queued_items),
                            32'(want.queued_items));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Pass driver
  always @(negedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || pass_xfer) begin
      if (gap_left != 0) begin
        drv_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pass_backlog.size() != 0) begin
        drv_data <= pass_backlog.pop_front();
        drv_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Result receiver; one forced long hold-off fills the block and stalls its input
  always @(negedge clk) begin
    if (hold_left != 0) begin
      rdy <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= 200) begin
      long_hold_done <= 1'b1;
      hold_left <= 80;
      rdy <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 20) begin
      hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      rdy <= 1'b0;
    end else begin
      rdy <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_pass(logic [31:0] now, logic [3:0] btn, logic [2:0] ends, logic busy);
    sbs_pkg::pass_t p;
    p.now_ms = now;
    p.buttons = btn;
    p.endstops = ends;
    p.motors_busy = busy;
    pass_backlog.push_back(p);
  endtask

  task automatic add_random_passes(int n);
    int k;
    int r;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 75) t_now = t_now + $urandom_range(0, 25);
      else if (r < 90) t_now = t_now + $urandom_range(0, 3000);
      else if (r < 96) t_now = t_now + $urandom_range(0, 70000);
      else t_now = $urandom;
      if ($urandom_range(0, 5) == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) held_btn = 4'd0;
        else if (r < 90) held_btn = 4'd1 << $urandom_range(0, 3);
        else held_btn = 4'($urandom_range(0, 15));
      end
      add_pass(t_now, held_btn, ($urandom_range(0, 9) < 4) ? 3'd0 : 3'($urandom_range(0, 7)),
               1'($urandom_range(0, 1)));
    end
  endtask

  // Nothing in flight: backlog empty, no item offered, every result in
  task automatic wait_drained();
    while (pass_backlog.size() != 0 || drv_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] scan_ms, logic [15:0] slide_ms, logic [2:0] presses);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sbs_pkg::CFG_SCAN_PERIOD;
    cfg_data <= scan_ms;
    @(negedge clk);
    cfg_index <= sbs_pkg::CFG_SLIDE_WAIT;
    cfg_data <= slide_ms;
    @(negedge clk);
    cfg_index <= sbs_pkg::CFG_HOMING_PRESS;
    cfg_data <= {13'd0, presses};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int ph;
    int k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beat cycle at reset settings
    add_pass(32'd0,    4'h0, 3'd0, 1'b1);  // too early to scan
    add_pass(32'd50,   4'h1, 3'd0, 1'b1);  // press edge, idle to prepare
    add_pass(32'd60,   4'h0, 3'd0, 1'b1);  // scan gated off, prepare pops
    add_pass(32'd110,  4'h2, 3'd0, 1'b1);
    add_pass(32'd120,  4'h2, 3'd0, 1'b0);  // motors settle, slide wait starts
    add_pass(32'd2119, 4'h2, 3'd0, 1'b0);
    add_pass(32'd2120, 4'h2, 3'd0, 1'b0);
    add_pass(32'd2121, 4'h2, 3'd0, 1'b0);
    add_pass(32'd2122, 4'h2, 3'd0, 1'b0);
    add_pass(32'd2123, 4'h2, 3'd0, 1'b1);
    add_pass(32'd3000, 4'h6, 3'd0, 1'b1);  // two held: flush and home
    add_pass(32'd3001, 4'h6, 3'd1, 1'b0);
    add_pass(32'd3002, 4'h6, 3'd7, 1'b1);  // all homed, back to idle
    add_pass(32'hFFFF_FFFF, 4'h0, 3'd0, 1'b0);
    add_pass(32'h0000_0031, 4'h8, 3'd0, 1'b0);  // elapsed time wraps past zero
    add_pass(32'h0000_0040, 4'h8, 3'd7, 1'b1);
    wait_drained();

    // Ring overflow: scan every pass, homing count that can never be reached
    write_regs(16'd0, 16'hFFFF, 3'd7);
    for (k = 0; k < 10; k++) add_pass(32'd5000 + k, (k % 2 == 0) ? 4'hF : 4'h0, 3'd0, 1'b1);
    t_now = 32'd6000;

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_regs(16'd0, 16'd0, 3'd2);
        1: write_regs(16'hFFFF, 16'hFFFF, 3'd4);
        2: write_regs(16'd5, 16'd20, 3'd3);
        3: write_regs(16'd1, 16'd0, 3'd1);
        4: write_regs(16'd10, 16'd100, 3'd0);
        5: write_regs(16'd20, 16'd5, 3'd5);
        default: write_regs(16'($urandom_range(0, 60)), 16'($urandom_range(0, 400)),
                            3'($urandom_range(0, 7)));
      endcase
      idle_on = (ph % 3 != 0);
      add_random_passes(105);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
